/* hdl/dat_pkg.sv */
package dat_pkg;

  // Default geometry and angle formats.
  localparam int COORD_BITS_DEF      = 20;
  localparam int ANGLE_FRAC_BITS_DEF = 7;

  // Fixed internal formats.
  localparam int SQRT_FRAC = 30;  // fraction bits of |r2|
  localparam int NORM_BITS = 30;  // magnitude bits fed to the rotator
  localparam int ZBITS     = 20;  // fraction bits of the angle accumulator
  localparam int NSTEPS    = 27;  // rotation steps
  localparam int OUT_W     = 16;  // width of the angle result
  localparam int MUL_PIECE = 24;  // operand slice of the split multiplier
  localparam int XW        = 34;  // rotator vector width
  localparam int ZW        = 30;  // rotator angle width

  // Elementary angles atan(2^-i) in units of 2^-ZBITS degree.
  function automatic int atan_entry(input int i);
    int v;
    unique case (i)
      0:  v = 47185920;
      1:  v = 27855475;
      2:  v = 14718068;
      3:  v = 7471121;
      4:  v = 3750058;
      5:  v = 1876857;
      6:  v = 938658;
      7:  v = 469357;
      8:  v = 234682;
      9:  v = 117342;
      10: v = 58671;
      11: v = 29335;
      12: v = 14668;
      13: v = 7334;
      14: v = 3667;
      15: v = 1833;
      16: v = 917;
      17: v = 458;
      18: v = 229;
      19: v = 115;
      20: v = 57;
      21: v = 29;
      22: v = 14;
      23: v = 7;
      24: v = 4;
      25: v = 2;
      26: v = 1;
      default: v = 0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/dat_if.sv */
// Input channel: four points per item.
interface dat_in_if import dat_pkg::*; #(parameter int CW = COORD_BITS_DEF) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] p1_x, p1_y, p1_z;
  logic signed [CW-1:0] p2_x, p2_y, p2_z;
  logic signed [CW-1:0] p3_x, p3_y, p3_z;
  logic signed [CW-1:0] p4_x, p4_y, p4_z;

  modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, input ready);
  modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, output ready);
endinterface

// Output channel: one angle per item.
interface dat_out_if import dat_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] torsion_deg;
  logic                    degenerate;

  modport source (output valid, torsion_deg, degenerate, input ready);
  modport sink (input valid, torsion_deg, degenerate, output ready);
endinterface

/* hdl/dat_mul.sv */
// Two-stage signed multiplier: sliced partial products, then their sum.
module dat_mul import dat_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);

  localparam int P   = MUL_PIECE;
  localparam int NA  = (AW + P - 1) / P;
  localparam int NB  = (BW + P - 1) / P;
  localparam int OW  = AW + BW;
  localparam int PPW = 2 * P + 2;

  logic signed [NA*P-1:0] a_ext;
  logic signed [NB*P-1:0] b_ext;
  logic signed [PPW-1:0]  pp [NA*NB];
  logic signed [OW-1:0]   acc;

  assign a_ext = (NA*P)'(a);
  assign b_ext = (NB*P)'(b);

  // Partial products; only the top slices carry the sign.
  for (genvar i = 0; i < NA; i++) begin : g_a
    for (genvar j = 0; j < NB; j++) begin : g_b
      logic signed [P:0] as_w, bs_w;
      assign as_w = (i == NA - 1) ? {a_ext[NA*P-1], a_ext[i*P +: P]}
                                  : {1'b0, a_ext[i*P +: P]};
      assign bs_w = (j == NB - 1) ? {b_ext[NB*P-1], b_ext[j*P +: P]}
                                  : {1'b0, b_ext[j*P +: P]};
      always_ff @(posedge clk) begin
        if (en) pp[i*NB+j] <= PPW'(as_w) * PPW'(bs_w);
      end
    end
  end

  // Weighted sum of the partial products.
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (OW'(pp[i*NB+j]) <<< ((i + j) * P));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) p <= acc;
  end

endmodule

/* hdl/dat_sqrt_cell.sv */
// One digit of a restoring square root; hands its partial root onward.
module dat_sqrt_cell import dat_pkg::*; #(
  parameter int RW = 51,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vi,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [PW-1:0]   pay_i,
  output logic            vo,
  output logic [RW+1:0]   rem_o,
  output logic [RW-1:0]   root_o,
  output logic [2*RW-1:0] rad_o,
  output logic [PW-1:0]   pay_o
);

  logic [RW+3:0] t_w, trial_w, diff_w;
  logic          ge_w;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    t_w     = {rem_i, rad_i[2*RW-1 -: 2]};
    trial_w = (RW+4)'({root_i, 2'b01});
    ge_w    = (t_w >= trial_w);
    diff_w  = t_w - trial_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge_w ? diff_w[RW+1:0] : t_w[RW+1:0];
      root_o <= {root_i[RW-2:0], ge_w};
      rad_o  <= {rad_i[2*RW-3:0], 2'b00};
      pay_o  <= pay_i;
    end
  end

endmodule

/* hdl/dat_cordic_cell.sv */
// One vectoring rotation step; drives y toward zero and sums the angle.
module dat_cordic_cell import dat_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vi,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic                 dgn_i,
  output logic                 vo,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output logic                 dgn_o
);

  localparam logic signed [ZW-1:0] ATAN = ZW'(atan_entry(STEP));

  logic signed [XW-1:0] ax_w, ay_w, sx_w, sy_w, dx_w, dy_w;
  logic                 up_w;

  // Shifts round toward zero, so they act on magnitudes.
  always_comb begin
    ax_w = x_i[XW-1] ? -x_i : x_i;
    ay_w = y_i[XW-1] ? -y_i : y_i;
    sx_w = ax_w >>> STEP;
    sy_w = ay_w >>> STEP;
    dx_w = y_i[XW-1] ? -sy_w : sy_w;
    dy_w = x_i[XW-1] ? -sx_w : sx_w;
    up_w = !y_i[XW-1] && (y_i != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (up_w) begin
        x_o <= x_i + dx_w;
        y_o <= y_i - dy_w;
        z_o <= z_i + ATAN;
      end else begin
        x_o <= x_i - dx_w;
        y_o <= y_i + dy_w;
        z_o <= z_i - ATAN;
      end
      dgn_o <= dgn_i;
    end
  end

endmodule

/* hdl/dihedral_angle_four_points_core.sv */
// Throughput: one item per cycle while the output skid register is empty; the square-root
// and rotation cell rows are fully pipelined.
// The pipeline advances whenever the output skid register is empty.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
module dihedral_angle_four_points_core import dat_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dat_in_if.sink     in_ch,
  dat_out_if.source  out_ch
);

  localparam int RB   = COORD_BITS + 1;
  localparam int NW   = 2 * RB + 1;
  localparam int DDW  = 2 * RB;
  localparam int SNW  = NW + RB + 2;
  localparam int CSW  = 2 * NW + 2;
  localparam int RW   = RB + SQRT_FRAC;
  localparam int SPW  = SNW + RW + 2;
  localparam int MW   = (SNW + RW > CSW + SQRT_FRAC) ? SNW + RW : CSW + SQRT_FRAC;
  localparam int LAW  = $clog2(MW + 1);
  localparam int PAYW = SNW + CSW + 2;
  localparam int NVW  = NORM_BITS + 1;
  localparam int SH   = ZBITS - ANGLE_FRAC_BITS;

  logic en;
  logic skid_v;

  assign en          = !skid_v;
  assign in_ch.ready = en;

  // Input points as an array.
  logic signed [COORD_BITS-1:0] pt [4][3];
  assign pt[0][0] = in_ch.p1_x;
  assign pt[0][1] = in_ch.p1_y;
  assign pt[0][2] = in_ch.p1_z;
  assign pt[1][0] = in_ch.p2_x;
  assign pt[1][1] = in_ch.p2_y;
  assign pt[1][2] = in_ch.p2_z;
  assign pt[2][0] = in_ch.p3_x;
  assign pt[2][1] = in_ch.p3_y;
  assign pt[2][2] = in_ch.p3_z;
  assign pt[3][0] = in_ch.p4_x;
  assign pt[3][1] = in_ch.p4_y;
  assign pt[3][2] = in_ch.p4_z;

  logic v1, v2, v3, v4, v5, v6, v7;
  logic signed [RB-1:0]    r1 [3], r2 [3], r3 [3], r3_2 [3], r3_3 [3];
  logic signed [2*RB-1:0]  c1a [3], c1b [3], c2a [3], c2b [3], sq [3];
  logic signed [NW-1:0]    n1 [3], n2 [3];
  logic signed [NW+RB-1:0] pd1 [3];
  logic signed [2*NW-1:0]  pd2 [3];
  logic [DDW-1:0]          dd3, dd4, dd5, dd6, dd7;
  logic signed [SNW-1:0]   sn6;
  logic signed [CSW-1:0]   cs6;
  logic [SNW-1:0]          sn_mag7;
  logic [CSW-1:0]          cs_mag7;
  logic                    sn_neg7, cs_neg7;

  // Bond vectors, cross-product terms, normals and squared |r2|.
  for (genvar j = 0; j < 3; j++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        r1[j]   <= RB'(pt[1][j]) - RB'(pt[0][j]);
        r2[j]   <= RB'(pt[2][j]) - RB'(pt[1][j]);
        r3[j]   <= RB'(pt[3][j]) - RB'(pt[2][j]);
        c1a[j]  <= (2*RB)'(r1[(j+1)%3]) * (2*RB)'(r2[(j+2)%3]);
        c1b[j]  <= (2*RB)'(r1[(j+2)%3]) * (2*RB)'(r2[(j+1)%3]);
        c2a[j]  <= (2*RB)'(r2[(j+1)%3]) * (2*RB)'(r3[(j+2)%3]);
        c2b[j]  <= (2*RB)'(r2[(j+2)%3]) * (2*RB)'(r3[(j+1)%3]);
        sq[j]   <= (2*RB)'(r2[j]) * (2*RB)'(r2[j]);
        r3_2[j] <= r3[j];
        n1[j]   <= NW'(c1a[j]) - NW'(c1b[j]);
        n2[j]   <= NW'(c2a[j]) - NW'(c2b[j]);
        r3_3[j] <= r3_2[j];
      end
    end

    dat_mul #(.AW(NW), .BW(RB)) u_mul_s (
      .clk(clk), .en(en), .a(n1[j]), .b(r3_3[j]), .p(pd1[j])
    );
    dat_mul #(.AW(NW), .BW(NW)) u_mul_c (
      .clk(clk), .en(en), .a(n1[j]), .b(n2[j]), .p(pd2[j])
    );
  end

  // Dot sums, then sign and magnitude of the sine and cosine terms.
  always_ff @(posedge clk) begin
    if (en) begin
      dd3 <= DDW'($unsigned(sq[0])) + DDW'($unsigned(sq[1])) + DDW'($unsigned(sq[2]));
      dd4 <= dd3;
      dd5 <= dd4;
      dd6 <= dd5;
      dd7 <= dd6;
      sn6 <= SNW'(pd1[0]) + SNW'(pd1[1]) + SNW'(pd1[2]);
      cs6 <= CSW'(pd2[0]) + CSW'(pd2[1]) + CSW'(pd2[2]);
      sn_neg7 <= sn6[SNW-1];
      cs_neg7 <= cs6[CSW-1];
      sn_mag7 <= sn6[SNW-1] ? $unsigned(-sn6) : $unsigned(sn6);
      cs_mag7 <= cs6[CSW-1] ? $unsigned(-cs6) : $unsigned(cs6);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // Square-root row: one root bit per cell, dot terms ride along.
  logic            sq_v    [RW+1];
  logic [RW+1:0]   sq_rem  [RW+1];
  logic [RW-1:0]   sq_root [RW+1];
  logic [2*RW-1:0] sq_rad  [RW+1];
  logic [PAYW-1:0] sq_pay  [RW+1];

  assign sq_v[0]    = v7;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = {dd7, (2*SQRT_FRAC)'(0)};
  assign sq_pay[0]  = {sn_neg7, sn_mag7, cs_neg7, cs_mag7};

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    dat_sqrt_cell #(.RW(RW), .PW(PAYW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vi(sq_v[k]), .rem_i(sq_rem[k]), .root_i(sq_root[k]),
      .rad_i(sq_rad[k]), .pay_i(sq_pay[k]),
      .vo(sq_v[k+1]), .rem_o(sq_rem[k+1]), .root_o(sq_root[k+1]),
      .rad_o(sq_rad[k+1]), .pay_o(sq_pay[k+1])
    );
  end

  // Sine term = |n1.r3| * |r2|.
  logic [SNW-1:0]        sn_mag_q;
  logic [CSW-1:0]        cs_mag_q, cs_mag_m1, cs_mag_m2;
  logic                  sn_neg_q, cs_neg_q;
  logic                  sn_neg_m1, sn_neg_m2, cs_neg_m1, cs_neg_m2;
  logic                  vm1, vm2;
  logic signed [SPW-1:0] sprod;

  assign {sn_neg_q, sn_mag_q, cs_neg_q, cs_mag_q} = sq_pay[RW];

  dat_mul #(.AW(SNW+1), .BW(RW+1)) u_mul_r (
    .clk(clk), .en(en),
    .a(signed'({1'b0, sn_mag_q})), .b(signed'({1'b0, sq_root[RW]})), .p(sprod)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      cs_mag_m1 <= cs_mag_q;
      cs_mag_m2 <= cs_mag_m1;
      sn_neg_m1 <= sn_neg_q;
      sn_neg_m2 <= sn_neg_m1;
      cs_neg_m1 <= cs_neg_q;
      cs_neg_m2 <= cs_neg_m1;
    end
  end

  // Leading-one search over both magnitudes.
  logic [MW-1:0]  smag_w, cmag_w, or_w;
  logic [LAW-1:0] la_w;

  always_comb begin
    smag_w = MW'(sprod[SNW+RW-1:0]);
    cmag_w = MW'(cs_mag_m2) << SQRT_FRAC;
    or_w   = smag_w | cmag_w;
    la_w   = '0;
    for (int k = 0; k < MW; k++) begin
      if (or_w[k]) la_w = LAW'(k + 1);
    end
  end

  logic [MW-1:0]  smag_a, cmag_a;
  logic [LAW-1:0] la_a;
  logic           sneg_a, cneg_a, dgn_a, va;

  always_ff @(posedge clk) begin
    if (en) begin
      smag_a <= smag_w;
      cmag_a <= cmag_w;
      la_a   <= la_w;
      sneg_a <= sn_neg_m2;
      cneg_a <= cs_neg_m2;
      dgn_a  <= (or_w == '0);
    end
  end

  // Common right shift to NORM_BITS bits, signs restored.
  logic [LAW-1:0]        shift_w;
  logic [NORM_BITS-1:0]  xs_w, ys_w;
  logic signed [NVW-1:0] xu_w, yu_w, x_b, y_b;
  logic                  dgn_b, vb;

  always_comb begin
    shift_w = (la_a > LAW'(NORM_BITS)) ? la_a - LAW'(NORM_BITS) : '0;
    xs_w    = NORM_BITS'(cmag_a >> shift_w);
    ys_w    = NORM_BITS'(smag_a >> shift_w);
    xu_w    = signed'({1'b0, xs_w});
    yu_w    = signed'({1'b0, ys_w});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_b   <= cneg_a ? -xu_w : xu_w;
      y_b   <= sneg_a ? -yu_w : yu_w;
      dgn_b <= dgn_a;
    end
  end

  // Left half plane: turn by a quarter first.
  logic signed [XW-1:0] cd_x [NSTEPS+1], cd_y [NSTEPS+1];
  logic signed [ZW-1:0] cd_z [NSTEPS+1];
  logic                 cd_v [NSTEPS+1], cd_dgn [NSTEPS+1];
  logic signed [XW-1:0] x_c, y_c;
  logic signed [ZW-1:0] z_c;
  logic                 dgn_c, vc;

  always_ff @(posedge clk) begin
    if (en) begin
      if (x_b[NVW-1]) begin
        if (!y_b[NVW-1]) begin
          x_c <= XW'(y_b);
          y_c <= -XW'(x_b);
          z_c <= ZW'(90) <<< ZBITS;
        end else begin
          x_c <= -XW'(y_b);
          y_c <= XW'(x_b);
          z_c <= -(ZW'(90) <<< ZBITS);
        end
      end else begin
        x_c <= XW'(x_b);
        y_c <= XW'(y_b);
        z_c <= '0;
      end
      dgn_c <= dgn_b;
    end
  end

  assign cd_x[0]   = x_c;
  assign cd_y[0]   = y_c;
  assign cd_z[0]   = z_c;
  assign cd_v[0]   = vc;
  assign cd_dgn[0] = dgn_c;

  for (genvar k = 0; k < NSTEPS; k++) begin : g_cordic
    dat_cordic_cell #(.STEP(k)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vi(cd_v[k]), .x_i(cd_x[k]), .y_i(cd_y[k]), .z_i(cd_z[k]), .dgn_i(cd_dgn[k]),
      .vo(cd_v[k+1]), .x_o(cd_x[k+1]), .y_o(cd_y[k+1]), .z_o(cd_z[k+1]),
      .dgn_o(cd_dgn[k+1])
    );
  end

  // Clamp to +-180 degrees and round halves away from zero.
  localparam logic signed [ZW-1:0] LIM  = ZW'(180) <<< ZBITS;
  localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (SH - 1);

  logic signed [ZW-1:0]    zc_w, mag_w, q_w;
  logic signed [OUT_W-1:0] ang_w, ang_d;
  logic                    dgn_d, vd;

  always_comb begin
    zc_w = cd_z[NSTEPS];
    if (zc_w > LIM) zc_w = LIM;
    if (zc_w < -LIM) zc_w = -LIM;
    mag_w = zc_w[ZW-1] ? -zc_w : zc_w;
    q_w   = (mag_w + HALF) >>> SH;
    ang_w = zc_w[ZW-1] ? -OUT_W'(q_w) : OUT_W'(q_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_d <= cd_dgn[NSTEPS] ? '0 : ang_w;
      dgn_d <= cd_dgn[NSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
      vm2 <= 1'b0;
      va  <= 1'b0;
      vb  <= 1'b0;
      vc  <= 1'b0;
      vd  <= 1'b0;
    end else if (en) begin
      vm1 <= sq_v[RW];
      vm2 <= vm1;
      va  <= vm2;
      vb  <= va;
      vc  <= vb;
      vd  <= cd_v[NSTEPS];
    end
  end

  // Output register with a skid stage behind it.
  logic                    out_v, fire;
  logic signed [OUT_W-1:0] out_ang, skid_ang;
  logic                    out_dgn, skid_dgn;

  assign fire = out_v && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (fire) skid_v <= 1'b0;
    end else if (vd) begin
      if (!out_v || fire) out_v <= 1'b1;
      else skid_v <= 1'b1;
    end else if (fire) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (fire) begin
        out_ang <= skid_ang;
        out_dgn <= skid_dgn;
      end
    end else if (vd) begin
      if (!out_v || fire) begin
        out_ang <= ang_d;
        out_dgn <= dgn_d;
      end else begin
        skid_ang <= ang_d;
        skid_dgn <= dgn_d;
      end
    end
  end

  assign out_ch.valid       = out_v;
  assign out_ch.torsion_deg = out_ang;
  assign out_ch.degenerate  = out_dgn;

endmodule

/* tb/dihedral_angle_four_points_core_tb.sv */
`timescale 1ns / 1ps

module dihedral_angle_four_points_core_tb;
  import dat_pkg::*;

  localparam int CB = 20;
  localparam int AFB = 7;
  localparam int K = 1024;
  localparam int CMAX = 524287;
  localparam int CMIN = -524288;
  localparam int N_RANDOM = 1050;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;

  typedef logic signed [191:0] wide_t;
  typedef logic signed [CB-1:0] coord_t;

  // One input item, with an optional typed-in expectation.
  typedef struct {
    int c[12];
    bit typed;
    int ang;
    bit dg;
  } point_row_t;

  typedef struct {
    logic signed [OUT_W-1:0] ang;
    logic dg;
  } angle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cyc = 0;
  int errors = 0;

  dat_in_if #(.CW(CB)) in_ch ();
  dat_out_if out_ch ();

  dihedral_angle_four_points_core #(.COORD_BITS(CB), .ANGLE_FRAC_BITS(AFB)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Elementary rotation angles in units of 2^-20 degree.
  localparam longint ATAN_DEG [27] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
    469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  // Torsion angle of four points by the core's fixed-point algorithm, rounded to 1/128 degree.
  function automatic angle_t torsion_of(input int c[12]);
    wide_t p[12];
    wide_t r1[3], r2[3], r3[3], n1[3], n2[3];
    wide_t dd, sn, cs, sn_mag, cs_mag, big, prod;
    logic [191:0] xs;
    logic [63:0] root, cand;
    longint x, y, z, t, dx, dy, mag, q;
    int la, shift, i;
    angle_t res;
    for (i = 0; i < 12; i++) p[i] = wide_t'(coord_t'(c[i]));
    for (i = 0; i < 3; i++) begin
      r1[i] = p[3 + i] - p[i];
      r2[i] = p[6 + i] - p[3 + i];
      r3[i] = p[9 + i] - p[6 + i];
    end
    n1[0] = r1[1] * r2[2] - r1[2] * r2[1];
    n1[1] = r1[2] * r2[0] - r1[0] * r2[2];
    n1[2] = r1[0] * r2[1] - r1[1] * r2[0];
    n2[0] = r2[1] * r3[2] - r2[2] * r3[1];
    n2[1] = r2[2] * r3[0] - r2[0] * r3[2];
    n2[2] = r2[0] * r3[1] - r2[1] * r3[0];
    dd = r2[0] * r2[0] + r2[1] * r2[1] + r2[2] * r2[2];
    xs = dd <<< (2 * SQRT_FRAC);
    // Bitwise floor square root of |r2|^2 scaled by 2^60.
    root = '0;
    for (i = 62; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      prod = wide_t'({128'd0, cand}) * wide_t'({128'd0, cand});
      if ($unsigned(prod) <= xs) root = cand;
    end
    sn = (n1[0] * r3[0] + n1[1] * r3[1] + n1[2] * r3[2]) * wide_t'({128'd0, root});
    cs = (n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2]) <<< SQRT_FRAC;
    if (sn == 0 && cs == 0) begin
      res.ang = '0;
      res.dg = 1'b1;
      return res;
    end
    sn_mag = sn < 0 ? -sn : sn;
    cs_mag = cs < 0 ? -cs : cs;
    big = sn_mag | cs_mag;
    la = 0;
    for (i = 0; i < 192; i++) if (big[i]) la = i + 1;
    shift = la > NORM_BITS ? la - NORM_BITS : 0;
    x = longint'((cs_mag >> shift) & ((wide_t'(1) <<< NORM_BITS) - 1));
    y = longint'((sn_mag >> shift) & ((wide_t'(1) <<< NORM_BITS) - 1));
    if (cs < 0) x = -x;
    if (sn < 0) y = -y;
    // Vectoring rotation, with a quarter turn first for the left half plane.
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 64'sd90 <<< ZBITS;
      end else begin
        t = x; x = -y; y = t; z = -(64'sd90 <<< ZBITS);
      end
    end
    for (i = 0; i < NSTEPS; i++) begin
      dx = y < 0 ? -((-y) >>> i) : (y >>> i);
      dy = x < 0 ? -((-x) >>> i) : (x >>> i);
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_DEG[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_DEG[i];
      end
    end
    if (z > (64'sd180 <<< ZBITS)) z = 64'sd180 <<< ZBITS;
    if (z < -(64'sd180 <<< ZBITS)) z = -(64'sd180 <<< ZBITS);
    mag = z < 0 ? -z : z;
    q = (mag + (64'sd1 <<< (ZBITS - AFB - 1))) >>> (ZBITS - AFB);
    if (z < 0) q = -q;
    res.ang = q[OUT_W-1:0];
    res.dg = 1'b0;
    return res;
  endfunction

  point_row_t stim_q[$];
  angle_t angle_q[$];
  point_row_t cur_row;
  int next_idx = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit stim_ready = 0;

  // Directed rows, then random point sets of several shapes.
  initial begin
    point_row_t row;
    int base[3];
    int mode, i, j, s;
    stim_q.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 1});
    stim_q.push_back('{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                         CMAX}, 1, 0, 1});
    stim_q.push_back('{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                         CMIN}, 1, 0, 1});
    stim_q.push_back('{'{0, 0, 0, K, K, K, 2*K, 2*K, 2*K, 3*K, 3*K, 3*K}, 1, 0, 1});
    stim_q.push_back('{'{K, 5, 7, K, 5, 7, 3*K, -K, 9, 12, 44, -K}, 1, 0, 1});
    stim_q.push_back('{'{K, 5, 7, 300, 2*K, 7, 300, 2*K, 7, 12, 44, -K}, 1, 0, 1});
    stim_q.push_back('{'{K, 0, 0, 0, 0, 0, 0, 0, K, K, 0, K}, 0, 0, 0});
    stim_q.push_back('{'{K, 0, 0, 0, 0, 0, 0, 0, K, 0, K, K}, 0, 0, 0});
    stim_q.push_back('{'{K, 0, 0, 0, 0, 0, 0, 0, K, 0, -K, K}, 0, 0, 0});
    stim_q.push_back('{'{K, 0, 0, 0, 0, 0, 0, 0, K, -K, 0, K}, 0, 0, 0});
    stim_q.push_back('{'{K, 0, 0, 0, 0, 0, 0, 0, K, K, K, K}, 0, 0, 0});
    stim_q.push_back('{'{K, 0, 0, 0, 0, 0, 0, 0, K, -K, -1, K}, 0, 0, 0});
    stim_q.push_back('{'{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN,
                         CMAX}, 0, 0, 0});
    stim_q.push_back('{'{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX,
                         CMIN}, 0, 0, 0});
    stim_q.push_back('{'{CMAX, 0, CMIN, 0, CMAX, 0, CMIN, 0, CMAX, 0, CMIN, 0}, 0, 0, 0});
    stim_q.push_back('{'{1, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1}, 0, 0, 0});
    for (i = 0; i < N_RANDOM; i++) begin
      row.typed = 0;
      row.ang = 0;
      row.dg = 0;
      mode = $urandom_range(0, 99);
      for (j = 0; j < 3; j++) base[j] = $urandom_range(0, 1048575) - 524288;
      for (j = 0; j < 12; j++) begin
        if (mode < 55) row.c[j] = $urandom_range(0, 1048575) - 524288;
        else if (mode < 85) row.c[j] = base[j % 3] + $urandom_range(0, 8191) - 4096;
        else if (mode < 93) row.c[j] = $urandom_range(0, 6) - 3;
        else row.c[j] = 0;
      end
      // Sparse points near the origin; for some, the second and third points coincide.
      if (mode >= 93) begin
        s = $urandom_range(0, 3);
        for (j = 0; j < 12; j++) row.c[j] = base[j % 3] / 4 * ((j / 3 == s) ? 1 : 0)
                                           + ($urandom_range(0, 1) ? (j / 3) * 37 : 0);
        if (mode >= 97) for (j = 0; j < 3; j++) row.c[3 + j] = row.c[6 + j];
      end
      stim_q.push_back(row);
    end
    stim_ready = 1;
  end

  // Sender: bursts of items with random gaps.
  always @(posedge clk) begin
    if (rst || !stim_ready) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (next_idx < stim_q.size()) begin
        cur_row <= stim_q[next_idx];
        {in_ch.p1_x, in_ch.p1_y, in_ch.p1_z} <= {coord_t'(stim_q[next_idx].c[0]),
            coord_t'(stim_q[next_idx].c[1]), coord_t'(stim_q[next_idx].c[2])};
        {in_ch.p2_x, in_ch.p2_y, in_ch.p2_z} <= {coord_t'(stim_q[next_idx].c[3]),
            coord_t'(stim_q[next_idx].c[4]), coord_t'(stim_q[next_idx].c[5])};
        {in_ch.p3_x, in_ch.p3_y, in_ch.p3_z} <= {coord_t'(stim_q[next_idx].c[6]),
            coord_t'(stim_q[next_idx].c[7]), coord_t'(stim_q[next_idx].c[8])};
        {in_ch.p4_x, in_ch.p4_y, in_ch.p4_z} <= {coord_t'(stim_q[next_idx].c[9]),
            coord_t'(stim_q[next_idx].c[10]), coord_t'(stim_q[next_idx].c[11])};
        in_ch.valid <= 1'b1;
        next_idx <= next_idx + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  initial begin
    {in_ch.p1_x, in_ch.p1_y, in_ch.p1_z, in_ch.p2_x, in_ch.p2_y, in_ch.p2_z} = '0;
    {in_ch.p3_x, in_ch.p3_y, in_ch.p3_z, in_ch.p4_x, in_ch.p4_y, in_ch.p4_z} = '0;
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Long receiver hold-off so the pipeline fills and stalls its input.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (cyc == 300) hold_left <= 500;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Receiver: phases of full rate, light stalls and heavy stalls.
  always @(posedge clk) begin
    if (rst || hold_left > 0) begin
      out_ch.ready <= 1'b0;
    end else begin
      case ((cyc / 700) % 3)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= $urandom_range(0, 3) != 0;
        end
        default: begin
          out_ch.ready <= $urandom_range(0, 9) < 3;
        end
      endcase
    end
  end

  // Record expected angles on input accept and compare them on output accept.
  always @(posedge clk) begin
    angle_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected item angle=%0d degenerate=%0b", $time,
                 out_ch.torsion_deg, out_ch.degenerate);
        errors++;
      end else begin
        want = angle_q.pop_front();
        if (out_ch.torsion_deg !== want.ang) begin
          $display("%0t: torsion_deg expected %0d actual %0d", $time, want.ang,
                   out_ch.torsion_deg);
          errors++;
        end
        if (out_ch.degenerate !== want.dg) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, want.dg,
                   out_ch.degenerate);
          errors++;
        end
      end
    end
    if (!rst && in_ch.valid && in_ch.ready) begin
      if (cur_row.typed) begin
        want.ang = cur_row.ang[OUT_W-1:0];
        want.dg = cur_row.dg;
      end else begin
        want = torsion_of(cur_row.c);
      end
      angle_q.push_back(want);
    end
  end

  // Cycle count and timeout.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("dihedral_angle_four_points_core_tb: FAIL");
      $finish;
    end
  end

  // Reset, then wait for all items to go through and drain.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!stim_ready || next_idx < stim_q.size() || in_ch.valid) @(posedge clk);
    while (angle_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("dihedral_angle_four_points_core_tb: PASS");
    end else begin
      $display("dihedral_angle_four_points_core_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/dat_pkg.sv
hdl/dat_if.sv
hdl/dat_mul.sv
hdl/dat_sqrt_cell.sv
hdl/dat_cordic_cell.sv
hdl/dihedral_angle_four_points_core.sv
tb/dihedral_angle_four_points_core_tb.sv
